// ===== sv/bmms_pkg.sv =====
package bmms_pkg;

  localparam int unsigned MaxSamplesDef = 4096;
  localparam int unsigned SampleBitsDef = 24;
  localparam int unsigned SampleW       = 24;
  localparam int unsigned MeanW         = 32;
  localparam int unsigned SigmaW        = 32;
  localparam int unsigned JobDepth      = 4;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } bmms_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] peak;
    logic signed [MeanW-1:0]   mean_q8;
    logic [SigmaW-1:0]         sigma_q8;
    logic                      overflowed;
  } bmms_out_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_N,
    BK_MUL_S,
    BK_SQRT,
    BK_DIV_M,
    BK_DIV_S,
    BK_OUT
  } bk_state_e;

endpackage

// ===== sv/block_max_mean_sigma_top.sv =====
// Per-block peak, mean and population standard deviation of signed samples.
// Input queue side: drive in_data_i and raise push_i; a sample is taken on a
// clock edge with push_i high and full_o low. Mark the final sample of a
// block with last. Up to one sample per cycle is accumulated.
// Result queue side: while empty_o is low, out_data_o holds the oldest
// result (peak, mean in Q.8, sigma in Q.8, overflow flag); pop_i takes it.
// The shift-add multiplies, the bit-serial square root and the restoring
// divider in the back end handle one block at a time; a new block is taken
// only once the last result is in the result register.
// Up to four finished blocks wait in the job queue; once three are queued,
// full_o rises and samples are held off. A stalled result receiver blocks the
// back end only; the front keeps accumulating until the queue fills.
// Reset clears the running state, the job queue and the result valid flag.
module block_max_mean_sigma_top import bmms_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  bmms_in_t  in_data_i,
  output logic      empty_o,
  input  logic      pop_i,
  output bmms_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = SAMPLE_BITS + CntW;
  localparam int unsigned SqW  = 2 * SAMPLE_BITS + CntW - 1;
  localparam int unsigned JobW = SAMPLE_BITS + SumW + SqW + CntW + 1;

  logic            accept, job_push, job_valid, job_pop, afull;
  logic [JobW-1:0] job_in, job_out;

  assign accept = push_i && !afull;
  assign full_o = afull;

  bmms_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .job_push_o(job_push),
    .job_data_o(job_in)
  );

  bmms_jobq #(
    .Width(JobW),
    .Depth(JobDepth)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .afull_o(afull),
    .valid_o(job_valid),
    .data_o (job_out),
    .pop_i  (job_pop)
  );

  bmms_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_data_i (job_out),
    .job_pop_o  (job_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== sv/bmms_jobq.sv =====
module bmms_jobq import bmms_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = JobDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             afull_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  // leave room for the one item still in the front's square stage
  assign afull_o = (cnt_q >= CntW'(Depth - 1));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bmms_front.sv =====
module bmms_front import bmms_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW = SAMPLE_BITS + CntW,
  localparam int unsigned SqW  = 2 * SAMPLE_BITS + CntW - 1,
  localparam int unsigned JobW = SAMPLE_BITS + SumW + SqW + CntW + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  bmms_in_t        in_data_i,
  output logic            job_push_o,
  output logic [JobW-1:0] job_data_o
);

  logic                          s1_vld_q, s1_last_q;
  logic signed [SAMPLE_BITS-1:0] s1_smp_q;
  logic [2*SAMPLE_BITS-1:0]      s1_sq_q;

  logic signed [SAMPLE_BITS-1:0]   smp_w;
  logic signed [2*SAMPLE_BITS-1:0] smp_x, sq_w;

  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  logic signed [SumW-1:0]        sum_q, sum_d;
  logic [SqW-1:0]                sq_q, sq_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          ovf_q, ovf_d;

  assign smp_w = in_data_i.sample[SAMPLE_BITS-1:0];
  assign smp_x = (2*SAMPLE_BITS)'(smp_w);
  assign sq_w  = smp_x * smp_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_last_q <= in_data_i.last;
      s1_smp_q  <= smp_w;
      s1_sq_q   <= sq_w;
    end
  end

  always_comb begin
    max_d = max_q;
    sum_d = sum_q;
    sq_d  = sq_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (s1_vld_q) begin
      if (cnt_q < CntW'(MAX_SAMPLES)) begin
        if (s1_smp_q > max_q) begin
          max_d = s1_smp_q;
        end
        sum_d = sum_q + SumW'(s1_smp_q);
        sq_d  = sq_q + SqW'(s1_sq_q);
        cnt_d = cnt_q + 1'b1;
      end else begin
        // block too long: drop the sample, flag it
        ovf_d = 1'b1;
      end
    end
  end

  assign job_push_o = s1_vld_q && s1_last_q;
  assign job_data_o = {max_d, sum_d, sq_d, cnt_d, ovf_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      sum_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (job_push_o) begin
      max_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      sum_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      max_q <= max_d;
      sum_q <= sum_d;
      sq_q  <= sq_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// ===== sv/bmms_back.sv =====
module bmms_back import bmms_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW = SAMPLE_BITS + CntW,
  localparam int unsigned SqW  = 2 * SAMPLE_BITS + CntW - 1,
  localparam int unsigned JobW = SAMPLE_BITS + SumW + SqW + CntW + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  logic [JobW-1:0] job_data_i,
  output logic            job_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output bmms_out_t       out_data_o
);

  localparam int unsigned VW    = CntW + SqW;
  localparam int unsigned XW    = ((VW + 17) / 2) * 2;
  localparam int unsigned RW    = XW / 2;
  localparam int unsigned DW0   = (SumW + 8 > RW) ? SumW + 8 : RW;
  localparam int unsigned DW    = (DW0 > MeanW) ? DW0 : MeanW;
  localparam int unsigned StepW = $clog2(DW + 1);

  bk_state_e st_q, st_d;

  logic signed [SAMPLE_BITS-1:0] j_max;
  logic signed [SumW-1:0]        j_sum;
  logic [SqW-1:0]                j_sq;
  logic [CntW-1:0]               j_cnt;
  logic                          j_ovf;

  logic signed [SAMPLE_BITS-1:0] peak_q;
  logic [CntW-1:0]               n_q;
  logic [SumW-1:0]               mag_q;
  logic                          neg_q, ovf_q;
  logic [SqW-1:0]                sumsq_q;
  logic [SumW-1:0]               msh_q;
  logic [VW-1:0]                 acc_q, sq2_q;
  logic [XW-1:0]                 x_q;
  logic [RW+1:0]                 rem_q;
  logic [RW-1:0]                 root_q;
  logic [DW-1:0]                 dv_q;
  logic [CntW-1:0]               dr_q;
  logic [StepW-1:0]              step_q;
  logic [MeanW-1:0]              mean_q;
  logic                          res_vld_q;
  bmms_out_t                     res_q;

  logic                          last_step, slot_free;
  logic [RW+1:0]                 rem2, trial;
  logic [CntW:0]                 dr2;
  logic                          dq_bit;

  assign {j_max, j_sum, j_sq, j_cnt, j_ovf} = job_data_i;

  assign last_step = (step_q == StepW'(1));
  assign slot_free = !res_vld_q || pop_i;

  // one root bit per step: bring down two radicand bits, try 4*root+1
  assign rem2  = {rem_q[RW-1:0], x_q[XW-1 -: 2]};
  assign trial = {root_q, 2'b01};

  // one quotient bit per step, restoring
  assign dr2    = {dr_q, dv_q[DW-1]};
  assign dq_bit = (dr2 >= {1'b0, n_q});

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE:  if (job_valid_i) st_d = BK_MUL_N;
      BK_MUL_N: if (last_step) st_d = BK_MUL_S;
      BK_MUL_S: if (last_step) st_d = BK_SQRT;
      BK_SQRT:  if (last_step) st_d = BK_DIV_M;
      BK_DIV_M: if (last_step) st_d = BK_DIV_S;
      BK_DIV_S: if (last_step) st_d = BK_OUT;
      BK_OUT:   if (slot_free) st_d = BK_IDLE;
      default:  st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = (st_q == BK_IDLE) && job_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= BK_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_OUT && slot_free) begin
        res_vld_q <= 1'b1;
      end else if (pop_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          peak_q  <= j_max;
          n_q     <= j_cnt;
          neg_q   <= j_sum[SumW-1];
          mag_q   <= j_sum[SumW-1] ? SumW'(-j_sum) : SumW'(j_sum);
          ovf_q   <= j_ovf;
          sumsq_q <= j_sq;
          msh_q   <= {j_cnt, {(SumW-CntW){1'b0}}};
          acc_q   <= '0;
          sq2_q   <= '0;
          step_q  <= StepW'(CntW);
        end
      end
      BK_MUL_N: begin
        acc_q <= {acc_q[VW-2:0], 1'b0} + (msh_q[SumW-1] ? VW'(sumsq_q) : '0);
        if (last_step) begin
          msh_q  <= mag_q;
          step_q <= StepW'(SumW - 1);
        end else begin
          msh_q  <= {msh_q[SumW-2:0], 1'b0};
          step_q <= step_q - 1'b1;
        end
      end
      BK_MUL_S: begin
        // the lowest bit of the square is folded into the first root step
        sq2_q <= {sq2_q[VW-2:0], 1'b0} + (msh_q[SumW-1] ? VW'(mag_q) : '0);
        msh_q <= {msh_q[SumW-2:0], 1'b0};
        if (last_step) begin
          step_q <= StepW'(RW + 1);
          rem_q  <= '0;
          root_q <= '0;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
      BK_SQRT: begin
        if (step_q == StepW'(RW + 1)) begin
          // first step: radicand is (n*sumsq - sum^2) * 65536, form it now
          x_q <= XW'({acc_q - ({sq2_q[VW-2:0], 1'b0} + (msh_q[SumW-1] ? VW'(mag_q) : '0)),
                      16'b0});
        end else begin
          x_q <= {x_q[XW-3:0], 2'b00};
          if (rem2 >= trial) begin
            rem_q  <= rem2 - trial;
            root_q <= {root_q[RW-2:0], 1'b1};
          end else begin
            rem_q  <= rem2;
            root_q <= {root_q[RW-2:0], 1'b0};
          end
        end
        if (last_step) begin
          step_q <= StepW'(DW);
          dv_q   <= DW'({mag_q, 8'b0});
          dr_q   <= '0;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
      BK_DIV_M, BK_DIV_S: begin
        if (last_step) begin
          step_q <= StepW'(DW);
          dr_q   <= '0;
          if (st_q == BK_DIV_M) begin
            // quotient of the mean is complete after this shift; apply the sign
            mean_q <= neg_q ? MeanW'(~{dv_q[DW-2:0], dq_bit} + 1'b1)
                            : MeanW'({dv_q[DW-2:0], dq_bit});
            dv_q   <= DW'(root_q);
          end else begin
            dv_q <= {dv_q[DW-2:0], dq_bit};
          end
        end else begin
          step_q <= step_q - 1'b1;
          dr_q   <= dq_bit ? CntW'(dr2 - {1'b0, n_q}) : dr2[CntW-1:0];
          dv_q   <= {dv_q[DW-2:0], dq_bit};
        end
      end
      BK_OUT: begin
        if (slot_free) begin
          res_q.peak       <= SampleW'(peak_q);
          res_q.mean_q8    <= mean_q;
          res_q.sigma_q8   <= dv_q[SigmaW-1:0];
          res_q.overflowed <= ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign empty_o    = !res_vld_q;
  assign out_data_o = res_q;

endmodule
